[hdl/pl0smc_pkg.sv]
// ----------------------------------------------------------------------------
// pl0smc_pkg: shared types and constants of the PL/0 stack machine core
// Item formats, instruction codes and the command and status groups that
// run between the controller and the datapath.
// ----------------------------------------------------------------------------
package pl0smc_pkg;

  // Default sizes of the word memory.
  localparam int MEM_DEPTH_DEF  = 512;
  localparam int WORD_WIDTH_DEF = 32;

  // Field widths fixed by the item formats.
  localparam int LEVEL_W   = 9;
  localparam int LEVEL_MAX = 511;

  // Instruction opcodes.
  localparam int OPC_LIT = 1;
  localparam int OPC_OPR = 2;
  localparam int OPC_LOD = 3;
  localparam int OPC_STO = 4;
  localparam int OPC_CAL = 5;
  localparam int OPC_INC = 6;
  localparam int OPC_JMP = 7;
  localparam int OPC_JPC = 8;
  localparam int OPC_SYS = 9;

  // OPR modifiers.
  localparam int OPR_RTN = 0;
  localparam int OPR_ADD = 1;
  localparam int OPR_SUB = 2;
  localparam int OPR_MUL = 3;
  localparam int OPR_DIV = 4;
  localparam int OPR_EQL = 5;
  localparam int OPR_NEQ = 6;
  localparam int OPR_LSS = 7;
  localparam int OPR_LEQ = 8;
  localparam int OPR_GTR = 9;
  localparam int OPR_GEQ = 10;
  localparam int OPR_ODD = 11;

  // SYS modifiers.
  localparam int SYS_OUT  = 1;
  localparam int SYS_IN   = 2;
  localparam int SYS_HALT = 3;

  // Item operation codes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef struct packed {
    logic               op;
    logic [8:0]         load_addr;
    logic signed [31:0] load_data;
    logic signed [31:0] sin_value;
  } req_t;

  typedef struct packed {
    logic [8:0]         pc;
    logic [8:0]         bp;
    logic [9:0]         sp;
    logic [3:0]         exec_opcode;
    logic [8:0]         exec_level;
    logic signed [31:0] exec_modifier;
    logic               out_valid;
    logic signed [31:0] out_value;
    logic               halted;
    logic               div_fault;
  } rsp_t;

  // Decoded instruction class.
  typedef enum logic [3:0] {
    CLS_NONE, CLS_LIT, CLS_RTN, CLS_ODD, CLS_ALU, CLS_MUL, CLS_DIV, CLS_LOD,
    CLS_STO, CLS_CAL, CLS_INC, CLS_JMP, CLS_JPC, CLS_OUT, CLS_IN, CLS_HALT
  } cls_t;

  // Datapath step selected by the controller.
  typedef enum logic [4:0] {
    STEP_IDLE, STEP_CLEAR, STEP_LOAD, STEP_F0, STEP_F1, STEP_F2, STEP_F3,
    STEP_F4, STEP_F5, STEP_WRD, STEP_WCAP, STEP_AINIT, STEP_AITER, STEP_EXEC,
    STEP_RTN0, STEP_RTN1, STEP_RTN2, STEP_LODR, STEP_LODW, STEP_CAL0,
    STEP_CAL1, STEP_CAL2, STEP_DONE
  } step_t;

  typedef struct packed {
    step_t step;
    logic  accept;
    logic  report;
  } cmd_t;

  typedef struct packed {
    cls_t cls;
    logic lev_zero;
    logic walk_one;
    logic arith_done;
    logic clear_done;
    logic item_op;
    logic halted;
  } status_t;

endpackage

[hdl/pl0smc_muldiv.sv]
// ----------------------------------------------------------------------------
// pl0smc_muldiv: iterative multiply and divide unit
// Shift-add multiply and restoring signed divide, one bit per cycle.
// ----------------------------------------------------------------------------
module pl0smc_muldiv #(
  parameter int WORD_WIDTH = pl0smc_pkg::WORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  is_div,
  input  logic [WORD_WIDTH-1:0] a,
  input  logic [WORD_WIDTH-1:0] b,
  output logic [WORD_WIDTH-1:0] result,
  output logic                  fault,
  output logic                  done
);

  localparam int W  = WORD_WIDTH;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  acc;
  logic [W-1:0]  q;
  logic [W-1:0]  d;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          mode_div;
  logic          neg;
  logic [W:0]    rem;
  logic [W:0]    rem_sub;
  logic [W-1:0]  a_mag;
  logic [W-1:0]  b_mag;

  // Magnitudes of the signed operands.
  assign a_mag   = a[W-1] ? (-a) : a;
  assign b_mag   = b[W-1] ? (-b) : b;
  assign rem     = {acc, q[W-1]};
  assign rem_sub = rem - {1'b0, d};

  // One multiply or divide bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      done     <= 1'b0;
      fault    <= 1'b0;
      mode_div <= is_div;
      acc      <= '0;
      cnt      <= CW'(W);
      if (is_div) begin
        q   <= a_mag;
        d   <= b_mag;
        neg <= a[W-1] ^ b[W-1];
        if (b == '0) begin
          fault  <= 1'b1;
          result <= '0;
          done   <= 1'b1;
          busy   <= 1'b0;
        end else begin
          busy <= 1'b1;
        end
      end else begin
        q    <= b;
        d    <= a;
        neg  <= 1'b0;
        busy <= 1'b1;
      end
    end else if (busy) begin
      if (mode_div) begin
        if (!rem_sub[W]) begin
          acc <= rem_sub[W-1:0];
          q   <= {q[W-2:0], 1'b1};
        end else begin
          acc <= rem[W-1:0];
          q   <= {q[W-2:0], 1'b0};
        end
      end else begin
        if (q[0]) begin
          acc <= acc + d;
        end
        d <= {d[W-2:0], 1'b0};
        q <= {1'b0, q[W-1:1]};
      end
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else if (done && !fault) begin
      // Final correction once the last bit is in.
      if (mode_div) begin
        result <= neg ? (-q) : q;
      end else begin
        result <= acc;
      end
      fault <= 1'b0;
    end
  end

endmodule

[hdl/pl0smc_ctrl.sv]
// ----------------------------------------------------------------------------
// pl0smc_ctrl: sequencer of the PL/0 stack machine core
// Steps the datapath through clearing, loading, fetch, link walk and execute,
// and runs both handshakes.
// ----------------------------------------------------------------------------
module pl0smc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  input  pl0smc_pkg::status_t  status,
  output pl0smc_pkg::cmd_t     cmd
);

  typedef enum logic [23:0] {
    ST_CLEAR = 24'h000001, ST_IDLE = 24'h000002, ST_LOAD = 24'h000004,
    ST_F0    = 24'h000008, ST_F1   = 24'h000010, ST_F2   = 24'h000020,
    ST_F3    = 24'h000040, ST_F4   = 24'h000080, ST_F5   = 24'h000100,
    ST_WRD   = 24'h000200, ST_WCAP = 24'h000400, ST_AINIT = 24'h000800,
    ST_AITER = 24'h001000, ST_EXEC = 24'h002000, ST_RTN0 = 24'h004000,
    ST_RTN1  = 24'h008000, ST_RTN2 = 24'h010000, ST_LODR = 24'h020000,
    ST_LODW  = 24'h040000, ST_CAL0 = 24'h080000, ST_CAL1 = 24'h100000,
    ST_CAL2  = 24'h200000, ST_DONE = 24'h400000, ST_SPARE = 24'h800000
  } state_t;

  state_t state;
  state_t state_next;
  state_t after_walk;
  logic   out_full;
  logic   out_full_next;
  logic   accept;
  logic   report;

  assign req_stall = (state != ST_IDLE);
  assign rsp_valid = out_full;
  assign accept    = req_valid && (state == ST_IDLE);
  assign report    = (state == ST_DONE) && (!out_full || !rsp_stall);

  // Where execution continues once the static links are followed.
  always_comb begin
    unique case (status.cls)
      pl0smc_pkg::CLS_LOD: after_walk = ST_LODR;
      pl0smc_pkg::CLS_CAL: after_walk = ST_CAL0;
      default:             after_walk = ST_EXEC;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (status.clear_done) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (status.item_op == pl0smc_pkg::OP_LOAD) state_next = ST_LOAD;
          else if (status.halted)                    state_next = ST_DONE;
          else                                       state_next = ST_F0;
        end
      end
      ST_LOAD: state_next = ST_DONE;
      ST_F0:   state_next = ST_F1;
      ST_F1:   state_next = ST_F2;
      ST_F2:   state_next = ST_F3;
      ST_F3:   state_next = ST_F4;
      ST_F4:   state_next = ST_F5;
      ST_F5: begin
        unique case (status.cls)
          pl0smc_pkg::CLS_LOD, pl0smc_pkg::CLS_STO, pl0smc_pkg::CLS_CAL:
            state_next = status.lev_zero ? after_walk : ST_WRD;
          pl0smc_pkg::CLS_MUL, pl0smc_pkg::CLS_DIV: state_next = ST_AINIT;
          pl0smc_pkg::CLS_RTN: state_next = ST_RTN0;
          default:             state_next = ST_EXEC;
        endcase
      end
      ST_WRD:   state_next = ST_WCAP;
      ST_WCAP:  state_next = status.walk_one ? after_walk : ST_WRD;
      ST_AINIT: state_next = ST_AITER;
      ST_AITER: if (status.arith_done) state_next = ST_EXEC;
      ST_EXEC:  state_next = ST_DONE;
      ST_RTN0:  state_next = ST_RTN1;
      ST_RTN1:  state_next = ST_RTN2;
      ST_RTN2:  state_next = ST_DONE;
      ST_LODR:  state_next = ST_LODW;
      ST_LODW:  state_next = ST_DONE;
      ST_CAL0:  state_next = ST_CAL1;
      ST_CAL1:  state_next = ST_CAL2;
      ST_CAL2:  state_next = ST_DONE;
      ST_DONE:  if (report) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Result register occupancy.
  always_comb begin
    out_full_next = out_full;
    if (report)         out_full_next = 1'b1;
    else if (!rsp_stall) out_full_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

  // Command to the datapath.
  always_comb begin
    cmd.accept = accept;
    cmd.report = report;
    unique case (state)
      ST_CLEAR: cmd.step = pl0smc_pkg::STEP_CLEAR;
      ST_LOAD:  cmd.step = pl0smc_pkg::STEP_LOAD;
      ST_F0:    cmd.step = pl0smc_pkg::STEP_F0;
      ST_F1:    cmd.step = pl0smc_pkg::STEP_F1;
      ST_F2:    cmd.step = pl0smc_pkg::STEP_F2;
      ST_F3:    cmd.step = pl0smc_pkg::STEP_F3;
      ST_F4:    cmd.step = pl0smc_pkg::STEP_F4;
      ST_F5:    cmd.step = pl0smc_pkg::STEP_F5;
      ST_WRD:   cmd.step = pl0smc_pkg::STEP_WRD;
      ST_WCAP:  cmd.step = pl0smc_pkg::STEP_WCAP;
      ST_AINIT: cmd.step = pl0smc_pkg::STEP_AINIT;
      ST_AITER: cmd.step = pl0smc_pkg::STEP_AITER;
      ST_EXEC:  cmd.step = pl0smc_pkg::STEP_EXEC;
      ST_RTN0:  cmd.step = pl0smc_pkg::STEP_RTN0;
      ST_RTN1:  cmd.step = pl0smc_pkg::STEP_RTN1;
      ST_RTN2:  cmd.step = pl0smc_pkg::STEP_RTN2;
      ST_LODR:  cmd.step = pl0smc_pkg::STEP_LODR;
      ST_LODW:  cmd.step = pl0smc_pkg::STEP_LODW;
      ST_CAL0:  cmd.step = pl0smc_pkg::STEP_CAL0;
      ST_CAL1:  cmd.step = pl0smc_pkg::STEP_CAL1;
      ST_CAL2:  cmd.step = pl0smc_pkg::STEP_CAL2;
      ST_DONE:  cmd.step = pl0smc_pkg::STEP_DONE;
      default:  cmd.step = pl0smc_pkg::STEP_IDLE;
    endcase
  end

endmodule

[hdl/pl0smc_datapath.sv]
// ----------------------------------------------------------------------------
// pl0smc_datapath: registers, word memory and arithmetic of the core
// Carries out the step that the controller selects and reports the decoded
// instruction and progress back to it.
// ----------------------------------------------------------------------------
module pl0smc_datapath #(
  parameter int MEM_DEPTH  = pl0smc_pkg::MEM_DEPTH_DEF,
  parameter int WORD_WIDTH = pl0smc_pkg::WORD_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  pl0smc_pkg::cmd_t    cmd,
  input  pl0smc_pkg::req_t    req,
  output pl0smc_pkg::status_t status,
  output pl0smc_pkg::rsp_t    rsp
);

  localparam int W   = WORD_WIDTH;
  localparam int AW  = $clog2(MEM_DEPTH);
  localparam int SPW = AW + 1;
  localparam int LW  = pl0smc_pkg::LEVEL_W;

  // Word memory, one port, registered read.
  logic [W-1:0]  mem [MEM_DEPTH];
  logic [W-1:0]  rdata;
  logic [AW-1:0] maddr;
  logic [W-1:0]  mwdata;
  logic          mwe;

  // Machine registers and the current item.
  logic [AW-1:0]  pc;
  logic [AW-1:0]  bp;
  logic [SPW-1:0] sp;
  logic           halt;
  logic [W-1:0]   opc;
  logic [W-1:0]   lw;
  logic [W-1:0]   m;
  logic [W-1:0]   a;
  logic [W-1:0]   b;
  logic [AW-1:0]  wbase;
  logic [LW-1:0]  wcnt;
  logic [AW-1:0]  clr_cnt;
  logic           ov;
  logic [31:0]    outv;
  logic           fault;
  pl0smc_pkg::req_t item;

  // Derived values.
  pl0smc_pkg::cls_t cls;
  logic [LW-1:0]  lev;
  logic [SPW-1:0] sp_dec;
  logic [SPW-1:0] sp_inc;
  logic [SPW-1:0] sp_incr;
  logic [W:0]     sp_ext;
  logic [W:0]     inc_up;
  logic [W:0]     inc_dn;
  logic [W-1:0]   m_mag;
  logic [AW-1:0]  sp_lo;
  logic [AW-1:0]  op_addr;
  logic [W-1:0]   alu_r;
  logic [W-1:0]   res;
  logic [63:0]    ld64;
  logic [63:0]    sin64;
  logic [63:0]    b64;
  logic [63:0]    m64;
  logic [63:0]    opc64;
  logic [31:0]    laddr32;
  logic [31:0]    pc32;
  logic [31:0]    bp32;
  logic [31:0]    sp32;
  logic [W-1:0]   md_res;
  logic           md_fault;
  logic           md_done;
  logic           md_start;

  // Instruction class from opcode and modifier.
  always_comb begin
    cls = pl0smc_pkg::CLS_NONE;
    if (opc == W'(pl0smc_pkg::OPC_LIT)) cls = pl0smc_pkg::CLS_LIT;
    else if (opc == W'(pl0smc_pkg::OPC_OPR)) begin
      if (m == W'(pl0smc_pkg::OPR_RTN))      cls = pl0smc_pkg::CLS_RTN;
      else if (m == W'(pl0smc_pkg::OPR_MUL)) cls = pl0smc_pkg::CLS_MUL;
      else if (m == W'(pl0smc_pkg::OPR_DIV)) cls = pl0smc_pkg::CLS_DIV;
      else if (m == W'(pl0smc_pkg::OPR_ODD)) cls = pl0smc_pkg::CLS_ODD;
      else if (m <= W'(pl0smc_pkg::OPR_GEQ)) cls = pl0smc_pkg::CLS_ALU;
    end
    else if (opc == W'(pl0smc_pkg::OPC_LOD)) cls = pl0smc_pkg::CLS_LOD;
    else if (opc == W'(pl0smc_pkg::OPC_STO)) cls = pl0smc_pkg::CLS_STO;
    else if (opc == W'(pl0smc_pkg::OPC_CAL)) cls = pl0smc_pkg::CLS_CAL;
    else if (opc == W'(pl0smc_pkg::OPC_INC)) cls = pl0smc_pkg::CLS_INC;
    else if (opc == W'(pl0smc_pkg::OPC_JMP)) cls = pl0smc_pkg::CLS_JMP;
    else if (opc == W'(pl0smc_pkg::OPC_JPC)) cls = pl0smc_pkg::CLS_JPC;
    else if (opc == W'(pl0smc_pkg::OPC_SYS)) begin
      if (m == W'(pl0smc_pkg::SYS_OUT))       cls = pl0smc_pkg::CLS_OUT;
      else if (m == W'(pl0smc_pkg::SYS_IN))   cls = pl0smc_pkg::CLS_IN;
      else if (m == W'(pl0smc_pkg::SYS_HALT)) cls = pl0smc_pkg::CLS_HALT;
    end
  end

  // Level count: negative counts as zero, large values clamp.
  always_comb begin
    if (lw[W-1])                               lev = '0;
    else if (lw > W'(pl0smc_pkg::LEVEL_MAX))   lev = LW'(pl0smc_pkg::LEVEL_MAX);
    else                                       lev = lw[LW-1:0];
  end

  // Stack pointer arithmetic, saturating to the empty mark and to zero.
  assign sp_dec  = (sp == '0) ? '0 : (sp - SPW'(1));
  assign sp_inc  = (sp == SPW'(MEM_DEPTH)) ? sp : (sp + SPW'(1));
  assign sp_ext  = (W+1)'(sp);
  assign m_mag   = m[W-1] ? (-m) : m;
  assign inc_up  = sp_ext + {1'b0, m_mag};
  assign inc_dn  = ({1'b0, m} > sp_ext) ? '0 : (sp_ext - {1'b0, m});
  assign sp_incr = m[W-1] ?
                   ((inc_up > (W+1)'(MEM_DEPTH)) ? SPW'(MEM_DEPTH) : inc_up[SPW-1:0]) :
                   inc_dn[SPW-1:0];
  assign sp_lo   = sp[AW-1:0];
  assign op_addr = wbase - m[AW-1:0];

  // Combinational OPR results.
  always_comb begin
    unique case (m[3:0])
      4'(pl0smc_pkg::OPR_ADD): alu_r = a + b;
      4'(pl0smc_pkg::OPR_SUB): alu_r = a - b;
      4'(pl0smc_pkg::OPR_EQL): alu_r = W'(a == b);
      4'(pl0smc_pkg::OPR_NEQ): alu_r = W'(a != b);
      4'(pl0smc_pkg::OPR_LSS): alu_r = W'($signed(a) < $signed(b));
      4'(pl0smc_pkg::OPR_LEQ): alu_r = W'(!($signed(b) < $signed(a)));
      4'(pl0smc_pkg::OPR_GTR): alu_r = W'($signed(b) < $signed(a));
      4'(pl0smc_pkg::OPR_GEQ): alu_r = W'(!($signed(a) < $signed(b)));
      default:                 alu_r = '0;
    endcase
  end
  assign res = ((cls == pl0smc_pkg::CLS_MUL) || (cls == pl0smc_pkg::CLS_DIV)) ?
               md_res : alu_r;

  // Resizing between the fixed item fields and the machine word.
  assign ld64    = {{32{item.load_data[31]}}, item.load_data};
  assign sin64   = {{32{item.sin_value[31]}}, item.sin_value};
  assign b64     = 64'(b);
  assign m64     = 64'(m);
  assign opc64   = 64'(opc);
  assign laddr32 = 32'(item.load_addr);
  assign pc32    = 32'(pc);
  assign bp32    = 32'(bp);
  assign sp32    = 32'(sp);

  assign md_start = (cmd.step == pl0smc_pkg::STEP_AINIT);

  pl0smc_muldiv #(
    .WORD_WIDTH(WORD_WIDTH)
  ) u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .start  (md_start),
    .is_div (cls == pl0smc_pkg::CLS_DIV),
    .a      (a),
    .b      (b),
    .result (md_res),
    .fault  (md_fault),
    .done   (md_done)
  );

  // Memory address and write data for each step.
  always_comb begin
    maddr  = pc;
    mwdata = '0;
    mwe    = 1'b0;
    unique case (cmd.step)
      pl0smc_pkg::STEP_CLEAR: begin
        maddr = clr_cnt;
        mwe   = 1'b1;
      end
      pl0smc_pkg::STEP_LOAD: begin
        maddr  = laddr32[AW-1:0];
        mwdata = ld64[W-1:0];
        mwe    = 1'b1;
      end
      pl0smc_pkg::STEP_F0: maddr = pc;
      pl0smc_pkg::STEP_F1: maddr = pc + AW'(1);
      pl0smc_pkg::STEP_F2: maddr = pc + AW'(2);
      pl0smc_pkg::STEP_F3: maddr = sp_lo + AW'(1);
      pl0smc_pkg::STEP_F4: maddr = sp_lo;
      pl0smc_pkg::STEP_WRD: maddr = wbase;
      pl0smc_pkg::STEP_LODR: maddr = op_addr;
      pl0smc_pkg::STEP_LODW: begin
        maddr  = sp_dec[AW-1:0];
        mwdata = rdata;
        mwe    = 1'b1;
      end
      pl0smc_pkg::STEP_RTN0: maddr = bp - AW'(1);
      pl0smc_pkg::STEP_RTN1: maddr = sp_lo - AW'(3);
      pl0smc_pkg::STEP_CAL0: begin
        maddr  = sp_lo - AW'(1);
        mwdata = W'(wbase);
        mwe    = 1'b1;
      end
      pl0smc_pkg::STEP_CAL1: begin
        maddr  = sp_lo - AW'(2);
        mwdata = W'(bp);
        mwe    = 1'b1;
      end
      pl0smc_pkg::STEP_CAL2: begin
        maddr  = sp_lo - AW'(3);
        mwdata = W'(pc);
        mwe    = 1'b1;
      end
      pl0smc_pkg::STEP_EXEC: begin
        unique case (cls)
          pl0smc_pkg::CLS_LIT: begin
            maddr  = sp_dec[AW-1:0];
            mwdata = m;
            mwe    = 1'b1;
          end
          pl0smc_pkg::CLS_ODD: begin
            maddr  = sp_lo;
            mwdata = W'(b[0]);
            mwe    = 1'b1;
          end
          pl0smc_pkg::CLS_ALU, pl0smc_pkg::CLS_MUL, pl0smc_pkg::CLS_DIV: begin
            maddr  = sp_lo + AW'(1);
            mwdata = res;
            mwe    = 1'b1;
          end
          pl0smc_pkg::CLS_STO: begin
            maddr  = op_addr;
            mwdata = b;
            mwe    = 1'b1;
          end
          pl0smc_pkg::CLS_IN: begin
            maddr  = sp_dec[AW-1:0];
            mwdata = sin64[W-1:0];
            mwe    = 1'b1;
          end
          default: mwe = 1'b0;
        endcase
      end
      default: mwe = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mwe) begin
      mem[maddr] <= mwdata;
    end
    rdata <= mem[maddr];
  end

  // Machine registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc      <= '0;
      bp      <= AW'(MEM_DEPTH - 1);
      sp      <= SPW'(MEM_DEPTH);
      halt    <= 1'b0;
      clr_cnt <= '0;
    end else begin
      if (cmd.accept) begin
        item  <= req;
        opc   <= '0;
        lw    <= '0;
        m     <= '0;
        ov    <= 1'b0;
        outv  <= '0;
        fault <= 1'b0;
      end
      unique case (cmd.step)
        pl0smc_pkg::STEP_CLEAR: clr_cnt <= clr_cnt + AW'(1);
        pl0smc_pkg::STEP_F1: opc <= rdata;
        pl0smc_pkg::STEP_F2: lw  <= rdata;
        pl0smc_pkg::STEP_F3: begin
          m  <= rdata;
          pc <= pc + AW'(3);
        end
        pl0smc_pkg::STEP_F4: a <= rdata;
        pl0smc_pkg::STEP_F5: begin
          b     <= rdata;
          wbase <= bp;
          wcnt  <= lev;
        end
        pl0smc_pkg::STEP_WCAP: begin
          wbase <= rdata[AW-1:0];
          wcnt  <= wcnt - LW'(1);
        end
        pl0smc_pkg::STEP_LODW: sp <= sp_dec;
        pl0smc_pkg::STEP_RTN0: sp <= SPW'(bp) + SPW'(1);
        pl0smc_pkg::STEP_RTN1: bp <= rdata[AW-1:0];
        pl0smc_pkg::STEP_RTN2: pc <= rdata[AW-1:0];
        pl0smc_pkg::STEP_CAL2: begin
          bp <= sp_lo - AW'(1);
          pc <= m[AW-1:0];
        end
        pl0smc_pkg::STEP_EXEC: begin
          unique case (cls)
            pl0smc_pkg::CLS_LIT, pl0smc_pkg::CLS_IN: sp <= sp_dec;
            pl0smc_pkg::CLS_ALU, pl0smc_pkg::CLS_STO: sp <= sp_inc;
            pl0smc_pkg::CLS_MUL: sp <= sp_inc;
            pl0smc_pkg::CLS_DIV: begin
              sp    <= sp_inc;
              fault <= md_fault;
            end
            pl0smc_pkg::CLS_INC: sp <= sp_incr;
            pl0smc_pkg::CLS_JMP: pc <= m[AW-1:0];
            pl0smc_pkg::CLS_JPC: begin
              if (b == '0) pc <= m[AW-1:0];
              sp <= sp_inc;
            end
            pl0smc_pkg::CLS_OUT: begin
              ov   <= 1'b1;
              outv <= b64[31:0];
              sp   <= sp_inc;
            end
            pl0smc_pkg::CLS_HALT: halt <= 1'b1;
            default: halt <= halt;
          endcase
        end
        default: halt <= halt;
      endcase
    end
  end

  // Result register, loaded once the item is finished.
  always_ff @(posedge clk) begin
    if (cmd.report) begin
      rsp.pc            <= pc32[8:0];
      rsp.bp            <= bp32[8:0];
      rsp.sp            <= sp32[9:0];
      rsp.exec_opcode   <= opc64[3:0];
      rsp.exec_level    <= lev;
      rsp.exec_modifier <= m64[31:0];
      rsp.out_valid     <= ov;
      rsp.out_value     <= outv;
      rsp.halted        <= halt;
      rsp.div_fault     <= fault;
    end
  end

  // Status to the controller.
  always_comb begin
    status.cls        = cls;
    status.lev_zero   = (lev == '0);
    status.walk_one   = (wcnt == LW'(1));
    status.arith_done = md_done;
    status.clear_done = (clr_cnt == AW'(MEM_DEPTH - 1));
    status.item_op    = req.op;
    status.halted     = halt;
  end

endmodule

[hdl/pl0_stack_machine_core_top.sv]
// ----------------------------------------------------------------------------
// pl0_stack_machine_core_top: PL/0 P-machine core
// One word memory holds program and downward-growing stack; items load words
// or execute one instruction each.
// ----------------------------------------------------------------------------
// After reset the core clears its word memory, one word a cycle, and holds
// req_stall high until that pass is over. It then works on one item at a time
// through its single memory port. A load beat writes its word and reports. A
// step beat does three fetch reads and two operand reads, then execute and
// report. LOD, STO and CAL also follow one static link per level, LOD adds a
// read and a write of memory, CAL and RTN further memory steps, and MUL and
// DIV wait on the bit-serial multiply and divide unit, which finishes early on
// a divide by zero. A step after halt goes straight to the report. The next
// beat can be taken in the cycle after the result is registered, also while
// the previous result still waits. MEM_DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module pl0_stack_machine_core_top #(
  parameter int MEM_DEPTH  = pl0smc_pkg::MEM_DEPTH_DEF,
  parameter int WORD_WIDTH = pl0smc_pkg::WORD_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  pl0smc_pkg::req_t req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output pl0smc_pkg::rsp_t rsp
);

  pl0smc_pkg::cmd_t    cmd;
  pl0smc_pkg::status_t status;

  // Sequencer.
  pl0smc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Registers, memory and arithmetic.
  pl0smc_datapath #(
    .MEM_DEPTH  (MEM_DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .req    (req),
    .status (status),
    .rsp    (rsp)
  );

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the PL/0 stack machine core
// Loads instruction words into the shared memory and steps the machine
// through them. A behavioural model of the machine predicts every result
// beat, and each beat is compared field by field as it is accepted.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DEPTH    = 512;
  localparam int WD_LIMIT = 20000;
  localparam int N_STEPS  = 400;

  logic             clk;
  logic             rst;
  logic             req_valid;
  logic             req_stall;
  pl0smc_pkg::req_t req;
  logic             rsp_valid;
  logic             rsp_stall;
  pl0smc_pkg::rsp_t rsp;

  pl0_stack_machine_core_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // Model state of the machine.
  logic [31:0] vm_mem [DEPTH];
  logic [8:0]  vm_pc;
  logic [8:0]  vm_bp;
  int          vm_sp;
  logic        vm_halt;

  pl0smc_pkg::rsp_t pending_rsp [$];
  int   n_errors;
  int   n_loads;
  int   n_steps;
  int   n_checked;
  int   opc_seen [16];
  int   n_faults;
  int   n_outs;
  bit   no_idle;
  int   stall_left;
  int   idle_cycles;

  // Clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stack pointer change, saturating to the memory range.
  function automatic int sp_move(int s, longint up, longint down);
    longint t;
    t = longint'(s) + up;
    if (t > DEPTH) t = DEPTH;
    if (down > t) t = 0;
    else t = t - down;
    return int'(t);
  endfunction

  // Follow static links lev levels down from the base pointer.
  function automatic logic [8:0] link_base(int lev);
    logic [8:0] bb;
    bb = vm_bp;
    repeat (lev) bb = vm_mem[bb][8:0];
    return bb;
  endfunction

  // Apply one item to the model and return the result it should give.
  function automatic pl0smc_pkg::rsp_t machine_apply(pl0smc_pkg::req_t r);
    pl0smc_pkg::rsp_t e;
    logic [31:0]      opw, lw, m, a, b, res;
    int               lev, s;
    logic [8:0]       ad;
    e = '0;
    if (r.op == pl0smc_pkg::OP_LOAD) begin
      vm_mem[r.load_addr] = r.load_data;
      n_loads++;
    end else if (!vm_halt) begin
      n_steps++;
      opw = vm_mem[vm_pc];
      lw  = vm_mem[vm_pc + 9'd1];
      m   = vm_mem[vm_pc + 9'd2];
      lev = lw[31] ? 0 : (lw > 32'd511 ? 511 : int'(lw));
      vm_pc = vm_pc + 9'd3;
      s = vm_sp;
      a = vm_mem[9'(s + 1)];
      b = vm_mem[9'(s)];
      opc_seen[opw[3:0]]++;
      case (opw)
        pl0smc_pkg::OPC_LIT: begin
          s = sp_move(s, 0, 1);
          vm_mem[9'(s)] = m;
        end
        pl0smc_pkg::OPC_OPR: begin
          if (m == pl0smc_pkg::OPR_RTN) begin
            s = sp_move(int'(vm_bp), 1, 0);
            vm_bp = vm_mem[9'(s + 510)][8:0];
            vm_pc = vm_mem[9'(s + 509)][8:0];
          end else if (m == pl0smc_pkg::OPR_ODD) begin
            vm_mem[9'(s)] = {31'b0, b[0]};
          end else if (m <= pl0smc_pkg::OPR_GEQ) begin
            res = '0;
            case (m)
              pl0smc_pkg::OPR_ADD: res = a + b;
              pl0smc_pkg::OPR_SUB: res = a - b;
              pl0smc_pkg::OPR_MUL: res = a * b;
              pl0smc_pkg::OPR_DIV: begin
                if (b == 0) begin
                  e.div_fault = 1'b1;
                  n_faults++;
                end else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
                  res = a;
                end else begin
                  res = $signed(a) / $signed(b);
                end
              end
              pl0smc_pkg::OPR_EQL: res = {31'b0, a == b};
              pl0smc_pkg::OPR_NEQ: res = {31'b0, a != b};
              pl0smc_pkg::OPR_LSS: res = {31'b0, $signed(a) < $signed(b)};
              pl0smc_pkg::OPR_LEQ: res = {31'b0, $signed(a) <= $signed(b)};
              pl0smc_pkg::OPR_GTR: res = {31'b0, $signed(a) > $signed(b)};
              default: res = {31'b0, $signed(a) >= $signed(b)};
            endcase
            vm_mem[9'(s + 1)] = res;
            s = sp_move(s, 1, 0);
          end
        end
        pl0smc_pkg::OPC_LOD: begin
          ad = link_base(lev) - m[8:0];
          s = sp_move(s, 0, 1);
          vm_mem[9'(s)] = vm_mem[ad];
        end
        pl0smc_pkg::OPC_STO: begin
          ad = link_base(lev) - m[8:0];
          vm_mem[ad] = b;
          s = sp_move(s, 1, 0);
        end
        pl0smc_pkg::OPC_CAL: begin
          ad = link_base(lev);
          vm_mem[9'(s + 511)] = {23'b0, ad};
          vm_mem[9'(s + 510)] = {23'b0, vm_bp};
          vm_mem[9'(s + 509)] = {23'b0, vm_pc};
          vm_bp = 9'(s + 511);
          vm_pc = m[8:0];
        end
        pl0smc_pkg::OPC_INC: begin
          if (m[31]) s = sp_move(s, -longint'($signed(m)), 0);
          else s = sp_move(s, 0, longint'({32'b0, m}));
        end
        pl0smc_pkg::OPC_JMP: vm_pc = m[8:0];
        pl0smc_pkg::OPC_JPC: begin
          if (b == 0) vm_pc = m[8:0];
          s = sp_move(s, 1, 0);
        end
        pl0smc_pkg::OPC_SYS: begin
          if (m == pl0smc_pkg::SYS_OUT) begin
            e.out_valid = 1'b1;
            e.out_value = b;
            n_outs++;
            s = sp_move(s, 1, 0);
          end else if (m == pl0smc_pkg::SYS_IN) begin
            s = sp_move(s, 0, 1);
            vm_mem[9'(s)] = r.sin_value;
          end else if (m == pl0smc_pkg::SYS_HALT) begin
            vm_halt = 1'b1;
          end
        end
        default: ;
      endcase
      vm_sp = s;
      e.exec_opcode   = opw[3:0];
      e.exec_level    = lev[8:0];
      e.exec_modifier = m;
    end
    e.pc     = vm_pc;
    e.bp     = vm_bp;
    e.sp     = vm_sp[9:0];
    e.halted = vm_halt;
    return e;
  endfunction

  // Idle gap before a beat: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = int'($urandom_range(0, 99));
    if (r < 50) return 0;
    if (r < 85) return int'($urandom_range(1, 3));
    if (r < 97) return int'($urandom_range(4, 10));
    return int'($urandom_range(20, 60));
  endfunction

  // Send one beat and record its expected result once it is taken.
  // Valid is left high after acceptance so that a back-to-back beat needs
  // only one assignment; any wait lowers it first.
  task automatic send_item(pl0smc_pkg::req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    pending_rsp.push_back(machine_apply(r));
  endtask

  task automatic load_word(logic [8:0] addr, logic [31:0] data);
    pl0smc_pkg::req_t r;
    r.op        = pl0smc_pkg::OP_LOAD;
    r.load_addr = addr;
    r.load_data = data;
    r.sin_value = $urandom;
    send_item(r);
  endtask

  task automatic step_once(logic [31:0] sin);
    pl0smc_pkg::req_t r;
    r.op        = pl0smc_pkg::OP_STEP;
    r.load_addr = 9'($urandom);
    r.load_data = $urandom;
    r.sin_value = sin;
    send_item(r);
  endtask

  // Place one instruction at the current program counter and execute it.
  task automatic run_insn(logic [31:0] opc, logic [31:0] lev, logic [31:0] md,
                          logic [31:0] sin);
    logic [8:0] at;
    at = vm_pc;
    load_word(at, opc);
    load_word(at + 9'd1, lev);
    load_word(at + 9'd2, md);
    step_once(sin);
  endtask

  // Hold the sender until every outstanding result has come back.
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on result %0d, %s: got %h, expected %h",
             n_checked, field, got, want);
    n_errors++;
  endtask

  // Result checker.
  always @(posedge clk) begin : check_results
    pl0smc_pkg::rsp_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        report("unexpected beat, pc", 32'(rsp.pc), 32'd0);
      end else begin
        e = pending_rsp.pop_front();
        if (rsp.pc != e.pc) report("pc", 32'(rsp.pc), 32'(e.pc));
        if (rsp.bp != e.bp) report("bp", 32'(rsp.bp), 32'(e.bp));
        if (rsp.sp != e.sp) report("sp", 32'(rsp.sp), 32'(e.sp));
        if (rsp.exec_opcode != e.exec_opcode)
          report("exec_opcode", 32'(rsp.exec_opcode), 32'(e.exec_opcode));
        if (rsp.exec_level != e.exec_level)
          report("exec_level", 32'(rsp.exec_level), 32'(e.exec_level));
        if (rsp.exec_modifier != e.exec_modifier)
          report("exec_modifier", rsp.exec_modifier, e.exec_modifier);
        if (rsp.out_valid != e.out_valid)
          report("out_valid", 32'(rsp.out_valid), 32'(e.out_valid));
        if (rsp.out_value != e.out_value)
          report("out_value", rsp.out_value, e.out_value);
        if (rsp.halted != e.halted)
          report("halted", 32'(rsp.halted), 32'(e.halted));
        if (rsp.div_fault != e.div_fault)
          report("div_fault", 32'(rsp.div_fault), 32'(e.div_fault));
        n_checked++;
      end
    end
  end

  // Receiver back-pressure: random short stalls with occasional long ones.
  always @(posedge clk) begin : drive_rsp_stall
    int r;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_stall  <= 1'b1;
    end else if (no_idle) begin
      rsp_stall <= 1'b0;
    end else begin
      r = int'($urandom_range(0, 99));
      if (r < 3) stall_left <= int'($urandom_range(10, 40));
      rsp_stall <= (r < 25);
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin : watchdog
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WD_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_rsp.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // A step on cleared memory decodes opcode zero and only advances pc.
  task automatic test_cleared_memory();
    step_once($urandom);
    step_once($urandom);
  endtask

  // Every opcode, with field extremes and the special cases; of OPR only DIV, ODD and RTN.
  task automatic test_directed_ops();
    load_word(9'd511, 32'h8000_0000);
    load_word(9'd0, 32'h7FFF_FFFF);
    run_insn(pl0smc_pkg::OPC_LIT, 0, 32'h8000_0000, 0);
    run_insn(pl0smc_pkg::OPC_LIT, 0, 32'hFFFF_FFFF, 0);
    run_insn(pl0smc_pkg::OPC_OPR, 0, pl0smc_pkg::OPR_DIV, 0);
    run_insn(pl0smc_pkg::OPC_LIT, 0, 0, 0);
    run_insn(pl0smc_pkg::OPC_OPR, 0, pl0smc_pkg::OPR_DIV, 0);
    run_insn(pl0smc_pkg::OPC_SYS, 0, pl0smc_pkg::SYS_IN, 32'h8000_0001);
    run_insn(pl0smc_pkg::OPC_OPR, 0, pl0smc_pkg::OPR_ODD, 0);
    run_insn(pl0smc_pkg::OPC_SYS, 0, pl0smc_pkg::SYS_OUT, 0);
    run_insn(pl0smc_pkg::OPC_INC, 32'hFFFF_FFFF, 32'h8000_0000, 0);
    run_insn(pl0smc_pkg::OPC_INC, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    run_insn(pl0smc_pkg::OPC_CAL, 1, 32'hFFFF_FE00, 0);
    run_insn(pl0smc_pkg::OPC_LOD, 511, 32'd3, 0);
    run_insn(pl0smc_pkg::OPC_STO, 2, 32'hFFFF_FFFD, 0);
    run_insn(pl0smc_pkg::OPC_JPC, 0, 32'd40, 0);
    run_insn(pl0smc_pkg::OPC_JMP, 0, 32'd100, 0);
    run_insn(pl0smc_pkg::OPC_OPR, 0, pl0smc_pkg::OPR_RTN, 0);
    run_insn(32'h0000_001F, 0, 32'd5, 0);
    run_insn(pl0smc_pkg::OPC_OPR, 0, 32'd12, 0);
    run_insn(pl0smc_pkg::OPC_SYS, 0, 32'd7, 0);
    drain();
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'(int'($urandom_range(0, 20)) - 10);
      default: return $urandom;
    endcase
  endfunction

  // Random instruction streams: mostly well-formed code with random content,
  // some odd encodings and stray loads into the memory.
  task automatic test_random_programs();
    logic [31:0] opc, lev, md;
    for (int i = 0; i < N_STEPS; i++) begin
      no_idle = (i % 100) >= 80;
      if ($urandom_range(0, 99) < 25) load_word(9'($urandom), rand_word());
      if ($urandom_range(0, 99) < 90)
        opc = 32'($urandom_range(pl0smc_pkg::OPC_LIT, pl0smc_pkg::OPC_SYS));
      else
        opc = rand_word();
      case ($urandom_range(0, 19))
        0: lev = 32'd511;
        1: lev = rand_word();
        2: lev = 32'($urandom_range(3, 12));
        default: lev = 32'($urandom_range(0, 2));
      endcase
      case (opc)
        pl0smc_pkg::OPC_OPR: begin
          if ($urandom_range(0, 9) < 9) md = 32'($urandom_range(0, 11));
          else md = rand_word();
        end
        pl0smc_pkg::OPC_SYS: begin
          if ($urandom_range(0, 9) < 9)
            md = 32'($urandom_range(pl0smc_pkg::SYS_OUT, pl0smc_pkg::SYS_IN));
          else
            md = $urandom;
        end
        pl0smc_pkg::OPC_INC: begin
          if ($urandom_range(0, 9) < 8) md = 32'(int'($urandom_range(0, 12)) - 6);
          else md = rand_word();
        end
        pl0smc_pkg::OPC_LOD, pl0smc_pkg::OPC_STO:
          md = 32'(int'($urandom_range(0, 8)) - 4);
        default: md = rand_word();
      endcase
      // Keep the machine running until the halt test.
      if (opc == pl0smc_pkg::OPC_SYS && md == pl0smc_pkg::SYS_HALT)
        md = pl0smc_pkg::SYS_OUT;
      run_insn(opc, lev, md, rand_word());
      if (i % 100 == 50) drain();
    end
    no_idle = 1'b0;
  endtask

  // Halt, then a step that must do nothing and a load that still writes.
  task automatic test_halt();
    run_insn(pl0smc_pkg::OPC_SYS, 0, pl0smc_pkg::SYS_HALT, 0);
    step_once($urandom);
    load_word(9'd5, 32'h1234_5678);
    step_once($urandom);
  endtask

  initial begin
    rst        = 1'b1;
    req_valid  = 1'b0;
    req        = '0;
    rsp_stall  = 1'b0;
    stall_left = 0;
    idle_cycles = 0;
    n_errors   = 0;
    n_loads    = 0;
    n_steps    = 0;
    n_checked  = 0;
    n_faults   = 0;
    n_outs     = 0;
    no_idle    = 1'b0;
    foreach (opc_seen[k]) opc_seen[k] = 0;
    foreach (vm_mem[k]) vm_mem[k] = '0;
    vm_pc   = '0;
    vm_bp   = 9'(DEPTH - 1);
    vm_sp   = DEPTH;
    vm_halt = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_cleared_memory();
    test_directed_ops();
    test_random_programs();
    test_halt();
    drain();
    repeat (100) @(posedge clk);

    $display("covered %0d loads and %0d executed steps, %0d results checked",
             n_loads, n_steps, n_checked);
    $display("LIT %0d OPR %0d LOD %0d STO %0d CAL %0d JMP %0d JPC %0d SYS %0d,",
             opc_seen[pl0smc_pkg::OPC_LIT], opc_seen[pl0smc_pkg::OPC_OPR],
             opc_seen[pl0smc_pkg::OPC_LOD], opc_seen[pl0smc_pkg::OPC_STO],
             opc_seen[pl0smc_pkg::OPC_CAL], opc_seen[pl0smc_pkg::OPC_JMP],
             opc_seen[pl0smc_pkg::OPC_JPC], opc_seen[pl0smc_pkg::OPC_SYS]);
    $display("%0d outputs and %0d divide faults", n_outs, n_faults);
    if (n_errors == 0 && pending_rsp.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
